>>> hdl/rla_pkg.sv
// rla_pkg: shared types and constants for the rgb lightness adjust block
// no dependencies
package rla_pkg;

    typedef struct packed {
        logic [7:0] in_red;
        logic [7:0] in_green;
        logic [7:0] in_blue;
        logic [7:0] brightness;
    } rgb_in_t;

    typedef struct packed {
        logic [7:0] out_red;
        logic [7:0] out_green;
        logic [7:0] out_blue;
        logic [7:0] in_lightness;
    } rgb_out_t;

    // divider lanes: numerator and denominator are small integers
    localparam int NUM_W = 11;
    localparam int LANES = 2;

    localparam int LANE_SAT  = 0;
    localparam int LANE_HUE  = 1;

    // lightness values carried beside the divider
    localparam int SIDES     = 2;
    localparam int SIDE_LIN  = 0;
    localparam int SIDE_LNEW = 1;

endpackage

>>> hdl/rla_front.sv
// rla_front: first stage, min/max, lightness, delta and hue numerator
// depends on rla_pkg
module rla_front #(
    parameter int FRAC_BITS = 16
) (
    input  logic                                          aclk,
    input  logic                                          aresetn,
    input  logic                                          ce,
    input  logic                                          in_valid,
    input  rla_pkg::rgb_in_t                              in_data,
    output logic                                          out_valid,
    output logic                                          out_grey,
    output logic [rla_pkg::LANES-1:0][rla_pkg::NUM_W-1:0] num_o,
    output logic [rla_pkg::LANES-1:0][rla_pkg::NUM_W-1:0] den_o,
    output logic [rla_pkg::SIDES-1:0][FRAC_BITS:0]        side_o
);
    import rla_pkg::*;

    localparam int QW     = FRAC_BITS + 1;
    localparam int Q_LNEW = (1 << FRAC_BITS) / 255;
    localparam int R_LNEW = (1 << FRAC_BITS) % 255;
    localparam int Q_LIN  = (1 << (FRAC_BITS - 1)) / 255;
    localparam int R_LIN  = (1 << (FRAC_BITS - 1)) % 255;

    logic [7:0]  r, g, b, mx, mn, d;
    logic [8:0]  sum, den_sat;
    logic signed [12:0] num_s, d_s;
    logic [NUM_W-1:0] num_hue, d6;
    logic [15:0] zl, zn;

    logic valid_reg;
    logic grey_reg, grey_next;
    logic [LANES-1:0][NUM_W-1:0] num_reg, num_next, den_reg, den_next;
    logic [SIDES-1:0][QW-1:0]    side_reg, side_next;

    // exact floor of z / 255 for z up to 65280
    function automatic logic [8:0] div255(input logic [15:0] z);
        logic [16:0] t;
        t = 17'(z) + 17'd1 + 17'(z[15:8]);
        return t[16:8];
    endfunction

    always_comb begin
        r = in_data.in_red;
        g = in_data.in_green;
        b = in_data.in_blue;
        mx = (r > g) ? r : g;
        mn = (r < g) ? r : g;
        if (b > mx) begin
            mx = b;
        end
        if (b < mn) begin
            mn = b;
        end
        sum = 9'(mx) + 9'(mn);
        d = mx - mn;
        den_sat = (sum > 9'd255) ? (9'd510 - sum) : sum;
        d_s = 13'(d);
        if (r > g && r > b) begin
            num_s = 13'(g) - 13'(b) + ((g < b) ? (d_s * 13'sd6) : 13'sd0);
        end else if (g > b) begin
            num_s = 13'(b) - 13'(r) + (d_s * 13'sd2);
        end else begin
            num_s = 13'(r) - 13'(g) + (d_s * 13'sd4);
        end
        num_hue = (num_s < 0) ? '0 : num_s[NUM_W-1:0];
        d6 = NUM_W'(d) * NUM_W'(6);
        grey_next = (mx == mn);
        num_next[LANE_SAT]  = NUM_W'(d);
        den_next[LANE_SAT]  = NUM_W'(den_sat);
        num_next[LANE_HUE]  = num_hue;
        den_next[LANE_HUE]  = d6;
        // divide by 255 as quotient and remainder of the constant scale
        zl = 16'(sum) * 16'(R_LIN);
        zn = 16'(in_data.brightness) * 16'(R_LNEW);
        side_next[SIDE_LIN]  = QW'(sum) * QW'(Q_LIN) + QW'(div255(zl));
        side_next[SIDE_LNEW] = QW'(in_data.brightness) * QW'(Q_LNEW) + QW'(div255(zn));
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else if (ce) begin
            valid_reg <= in_valid;
        end
    end

    always_ff @(posedge aclk) begin
        if (ce) begin
            grey_reg <= grey_next;
            num_reg  <= num_next;
            den_reg  <= den_next;
            side_reg <= side_next;
        end
    end

    assign out_valid = valid_reg;
    assign out_grey  = grey_reg;
    assign num_o     = num_reg;
    assign den_o     = den_reg;
    assign side_o    = side_reg;

endmodule

>>> hdl/rla_div.sv
// rla_div: pipelined restoring divider, two lanes, one quotient bit per stage
// computes (num << FRAC_BITS) / den and delays the lightness values alongside; depends on rla_pkg
module rla_div #(
    parameter int FRAC_BITS = 16
) (
    input  logic                                          aclk,
    input  logic                                          aresetn,
    input  logic                                          ce,
    input  logic                                          in_valid,
    input  logic                                          in_grey,
    input  logic [rla_pkg::LANES-1:0][rla_pkg::NUM_W-1:0] num_i,
    input  logic [rla_pkg::LANES-1:0][rla_pkg::NUM_W-1:0] den_i,
    input  logic [rla_pkg::SIDES-1:0][FRAC_BITS:0]        side_i,
    output logic                                          out_valid,
    output logic                                          out_grey,
    output logic [rla_pkg::LANES-1:0][FRAC_BITS:0]        quo_o,
    output logic [rla_pkg::SIDES-1:0][FRAC_BITS:0]        side_o
);
    import rla_pkg::*;

    localparam int QW = FRAC_BITS + 1;

    logic [NUM_W-1:0] rem_reg  [QW][LANES];
    logic [NUM_W-1:0] rem_next [QW][LANES];
    logic [NUM_W-1:0] den_reg  [QW][LANES];
    logic [NUM_W-1:0] den_next [QW][LANES];
    logic [QW-1:0]    q_reg    [QW][LANES];
    logic [QW-1:0]    q_next   [QW][LANES];
    logic [QW-1:0]    bits_reg [QW][LANES];
    logic [QW-1:0]    bits_next[QW][LANES];
    logic [SIDES-1:0][QW-1:0] side_reg [QW];
    logic [QW-1:0]    valid_reg;
    logic [QW-1:0]    grey_reg;

    always_comb begin
        logic [NUM_W-1:0] p_rem, p_den;
        logic [QW-1:0]    p_q, p_bits;
        logic [NUM_W:0]   trial, diff;
        logic             ge;
        for (int s = 0; s < QW; s++) begin
            for (int l = 0; l < LANES; l++) begin
                if (s == 0) begin
                    p_rem  = {1'b0, num_i[l][NUM_W-1:1]};
                    p_bits = {num_i[l][0], {FRAC_BITS{1'b0}}};
                    p_q    = '0;
                    p_den  = den_i[l];
                end else begin
                    p_rem  = rem_reg[s-1][l];
                    p_bits = bits_reg[s-1][l];
                    p_q    = q_reg[s-1][l];
                    p_den  = den_reg[s-1][l];
                end
                trial = {p_rem, p_bits[QW-1]};
                diff  = trial - {1'b0, p_den};
                ge    = (trial >= {1'b0, p_den});
                rem_next[s][l]  = ge ? diff[NUM_W-1:0] : trial[NUM_W-1:0];
                q_next[s][l]    = {p_q[QW-2:0], ge};
                bits_next[s][l] = p_bits << 1;
                den_next[s][l]  = p_den;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (ce) begin
            rem_reg  <= rem_next;
            q_reg    <= q_next;
            bits_reg <= bits_next;
            den_reg  <= den_next;
            grey_reg <= {grey_reg[QW-2:0], in_grey};
            side_reg[0] <= side_i;
            for (int s = 1; s < QW; s++) begin
                side_reg[s] <= side_reg[s-1];
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= '0;
        end else if (ce) begin
            valid_reg <= {valid_reg[QW-2:0], in_valid};
        end
    end

    always_comb begin
        for (int l = 0; l < LANES; l++) begin
            quo_o[l] = q_reg[QW-1][l];
        end
    end

    assign out_valid = valid_reg[QW-1];
    assign out_grey  = grey_reg[QW-1];
    assign side_o    = side_reg[QW-1];

endmodule

>>> hdl/rla_back.sv
// rla_back: hsl to rgb stages and byte conversion, ending in the output register
// depends on rla_pkg
module rla_back #(
    parameter int FRAC_BITS = 16
) (
    input  logic                                   aclk,
    input  logic                                   aresetn,
    input  logic                                   ce,
    input  logic                                   in_valid,
    input  logic                                   in_grey,
    input  logic [rla_pkg::LANES-1:0][FRAC_BITS:0] quo_i,
    input  logic [rla_pkg::SIDES-1:0][FRAC_BITS:0] side_i,
    output logic                                   m_valid,
    output rla_pkg::rgb_out_t                      m_data
);
    import rla_pkg::*;

    localparam int QW = FRAC_BITS + 1;
    localparam int HW = QW + 1;
    localparam int TW = FRAC_BITS + 5;
    localparam int XW = HW + 9;

    localparam logic [QW-1:0] HALF_Q = QW'(1) << (FRAC_BITS - 1);
    localparam logic signed [TW-1:0] ONE_T   = TW'(1) << FRAC_BITS;
    localparam logic signed [TW-1:0] THIRD_T = TW'(2) << FRAC_BITS;
    localparam logic signed [TW-1:0] THREE_T = TW'(3) << FRAC_BITS;
    localparam logic signed [TW-1:0] FOUR_T  = TW'(4) << FRAC_BITS;
    localparam logic signed [TW-1:0] SIX_T   = TW'(6) << FRAC_BITS;
    localparam logic [XW-1:0] HALF_X = XW'(1) << (FRAC_BITS - 1);

    typedef enum logic [1:0] {REG_RISE, REG_HIGH, REG_FALL, REG_LOW} region_t;

    typedef struct packed {
        region_t       region;
        logic [QW-1:0] fac;
    } chan_t;

    function automatic chan_t chan_pos(input logic signed [TW-1:0] t_in);
        logic signed [TW-1:0] t, rest;
        chan_t c;
        t = t_in;
        if (t < 0) begin
            t = t + SIX_T;
        end
        if (t > SIX_T) begin
            t = t - SIX_T;
        end
        rest = FOUR_T - t;
        c.fac = '0;
        priority if (t < ONE_T) begin
            c.region = REG_RISE;
            c.fac    = t[QW-1:0];
        end else if (t < THREE_T) begin
            c.region = REG_HIGH;
        end else if (t < FOUR_T) begin
            c.region = REG_FALL;
            c.fac    = rest[QW-1:0];
        end else begin
            c.region = REG_LOW;
        end
        return c;
    endfunction

    function automatic logic [7:0] to_byte(input logic [HW-1:0] v);
        logic [XW-1:0] x;
        logic [XW-FRAC_BITS-1:0] q;
        x = XW'({v, 8'h00}) - XW'(v) + HALF_X;
        q = x[XW-1:FRAC_BITS];
        return (q > (XW-FRAC_BITS)'(255)) ? 8'hFF : q[7:0];
    endfunction

    // stage 1: lightness times saturation
    logic          v1_reg, grey1_reg;
    logic [QW-1:0] prod1_reg, lnew1_reg, sat1_reg, hue1_reg, lin1_reg;

    // stage 2: hi, lo and channel positions
    logic          v2_reg, grey2_reg;
    logic [HW-1:0] hi2_reg, lo2_reg, span2_reg, lnew2_reg, lin2_reg;
    chan_t         ch2_reg [3];
    logic [HW-1:0] hi_next, lo_next, two_l;
    logic signed [TW-1:0] t6, hue_s;
    chan_t         ch_next [3];

    // stage 3: channel levels
    logic          v3_reg;
    logic [HW-1:0] lvl3_reg [3];
    logic [HW-1:0] lin3_reg;
    logic [HW-1:0] lvl_next [3];

    // output register
    logic     m_valid_reg;
    rgb_out_t m_data_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            v1_reg      <= 1'b0;
            v2_reg      <= 1'b0;
            v3_reg      <= 1'b0;
            m_valid_reg <= 1'b0;
        end else if (ce) begin
            v1_reg      <= in_valid;
            v2_reg      <= v1_reg;
            v3_reg      <= v2_reg;
            m_valid_reg <= v3_reg;
        end
    end

    logic [2*QW-1:0] prod_in;
    assign prod_in = side_i[SIDE_LNEW] * quo_i[LANE_SAT];

    always_ff @(posedge aclk) begin
        if (ce) begin
            grey1_reg <= in_grey;
            prod1_reg <= prod_in[FRAC_BITS +: QW];
            lnew1_reg <= side_i[SIDE_LNEW];
            sat1_reg  <= quo_i[LANE_SAT];
            hue1_reg  <= quo_i[LANE_HUE];
            lin1_reg  <= side_i[SIDE_LIN];
        end
    end

    always_comb begin
        if (lnew1_reg < HALF_Q) begin
            hi_next = HW'(lnew1_reg) + HW'(prod1_reg);
        end else begin
            hi_next = HW'(lnew1_reg) + HW'(sat1_reg) - HW'(prod1_reg);
        end
        two_l   = {lnew1_reg, 1'b0};
        lo_next = (two_l >= hi_next) ? (two_l - hi_next) : '0;
        hue_s   = signed'(TW'(hue1_reg));
        t6      = (hue_s <<< 2) + (hue_s <<< 1);
        ch_next[0] = chan_pos(t6 + THIRD_T);
        ch_next[1] = chan_pos(t6);
        ch_next[2] = chan_pos(t6 - THIRD_T);
    end

    always_ff @(posedge aclk) begin
        if (ce) begin
            grey2_reg <= grey1_reg;
            hi2_reg   <= hi_next;
            lo2_reg   <= lo_next;
            span2_reg <= hi_next - lo_next;
            lnew2_reg <= HW'(lnew1_reg);
            lin2_reg  <= HW'(lin1_reg);
            ch2_reg   <= ch_next;
        end
    end

    always_comb begin
        logic [HW+QW-1:0] ramp;
        for (int c = 0; c < 3; c++) begin
            ramp = span2_reg * ch2_reg[c].fac;
            unique case (ch2_reg[c].region)
                REG_RISE, REG_FALL: lvl_next[c] = lo2_reg + ramp[FRAC_BITS +: HW];
                REG_HIGH:           lvl_next[c] = hi2_reg;
                REG_LOW:            lvl_next[c] = lo2_reg;
                default:            lvl_next[c] = lo2_reg;
            endcase
            if (grey2_reg) begin
                lvl_next[c] = lnew2_reg;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (ce) begin
            lvl3_reg <= lvl_next;
            lin3_reg <= lin2_reg;
            m_data_reg.out_red      <= to_byte(lvl3_reg[0]);
            m_data_reg.out_green    <= to_byte(lvl3_reg[1]);
            m_data_reg.out_blue     <= to_byte(lvl3_reg[2]);
            m_data_reg.in_lightness <= to_byte(lin3_reg);
        end
    end

    assign m_valid = m_valid_reg;
    assign m_data  = m_data_reg;

endmodule

>>> hdl/rgb_lightness_adjust.sv
// channel  | ports                      | payload
// s_       | s_valid s_ready s_data     | rgb_in_t: red, green, blue, brightness
// m_       | m_valid m_ready m_data     | rgb_out_t: red, green, blue, input lightness
// one request per cycle unless the output stalls; stages: one front stage, one
// divider stage per quotient bit (FRAC_BITS + 1), three hsl to rgb stages, output register
// a stalled output freezes the whole pipeline; s_ready is low only then
// aresetn clears valid bits only, no clearing pass
module rgb_lightness_adjust #(
    parameter int FRAC_BITS = 16
) (
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              s_valid,
    output logic              s_ready,
    input  rla_pkg::rgb_in_t  s_data,
    output logic              m_valid,
    input  logic              m_ready,
    output rla_pkg::rgb_out_t m_data
);
    import rla_pkg::*;

    logic ce;
    logic f_valid, f_grey, d_valid, d_grey;
    logic [LANES-1:0][NUM_W-1:0] f_num, f_den;
    logic [LANES-1:0][FRAC_BITS:0] d_quo;
    logic [SIDES-1:0][FRAC_BITS:0] f_side, d_side;

    assign ce      = !m_valid || m_ready;
    assign s_ready = ce;

    rla_front #(.FRAC_BITS(FRAC_BITS)) u_front (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .ce        (ce),
        .in_valid  (s_valid),
        .in_data   (s_data),
        .out_valid (f_valid),
        .out_grey  (f_grey),
        .num_o     (f_num),
        .den_o     (f_den),
        .side_o    (f_side)
    );

    rla_div #(.FRAC_BITS(FRAC_BITS)) u_div (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .ce        (ce),
        .in_valid  (f_valid),
        .in_grey   (f_grey),
        .num_i     (f_num),
        .den_i     (f_den),
        .side_i    (f_side),
        .out_valid (d_valid),
        .out_grey  (d_grey),
        .quo_o     (d_quo),
        .side_o    (d_side)
    );

    rla_back #(.FRAC_BITS(FRAC_BITS)) u_back (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .ce       (ce),
        .in_valid (d_valid),
        .in_grey  (d_grey),
        .quo_i    (d_quo),
        .side_i   (d_side),
        .m_valid  (m_valid),
        .m_data   (m_data)
    );

endmodule

>>> hdl/rla_checker.sv
// rla_checker: port level checks for rgb_lightness_adjust, bound to the top level
// depends on rla_pkg
module rla_checker (
    input logic              aclk,
    input logic              aresetn,
    input logic              s_valid,
    input logic              s_ready,
    input rla_pkg::rgb_in_t  s_data,
    input logic              m_valid,
    input logic              m_ready,
    input rla_pkg::rgb_out_t m_data
);
    import rla_pkg::*;

    // held result keeps its value
    a_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_ready |=> m_valid && $stable(m_data))
        else $error("result changed while stalled");

    // result only leaves when taken
    a_drop: assert property (@(posedge aclk) disable iff (!aresetn)
        $fell(m_valid) |-> $past(m_ready))
        else $error("result dropped without handshake");

    // input refused only behind a stalled result
    a_ready: assert property (@(posedge aclk) disable iff (!aresetn)
        !s_ready |-> m_valid && !m_ready)
        else $error("input refused without output stall");

    // waiting request keeps its value
    a_in_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        s_valid && !s_ready |=> s_valid && $stable(s_data))
        else $error("request changed while waiting");

    // reset empties the pipeline
    a_reset: assert property (@(posedge aclk)
        !aresetn |=> !m_valid)
        else $error("result valid after reset");

endmodule

bind rgb_lightness_adjust rla_checker u_chk (.*);

>>> test/rgb_lightness_adjust_tb.sv
// rgb_lightness_adjust_tb: checks the lightness replacement block against an hsl predictor
// directed table of colors and brightness levels, then random requests with random idling
// depends on rla_pkg and rgb_lightness_adjust
module rgb_lightness_adjust_tb;
    import rla_pkg::*;

    localparam int FRAC_BITS = 16;
    localparam longint FX_ONE = longint'(1) << FRAC_BITS;
    localparam int RANDOM_COUNT = 1100;
    localparam int STALL_LIMIT = 20000;
    localparam int DRAIN_CYCLES = FRAC_BITS + 20;

    typedef struct {
        rgb_in_t  req;
        logic     known;
        rgb_out_t res;
    } table_row_t;

    logic     aclk = 1'b0;
    logic     aresetn = 1'b0;
    logic     s_valid = 1'b0;
    logic     s_ready;
    rgb_in_t  s_data = '0;
    logic     m_valid;
    logic     m_ready = 1'b0;
    rgb_out_t m_data;

    rgb_out_t expected_colors[$];
    int       failures = 0;
    int       quiet_cycles = 0;
    bit       sending_done = 1'b0;
    bit       hold_off = 1'b0;
    bit       steady = 1'b0;

    rgb_lightness_adjust #(.FRAC_BITS(FRAC_BITS)) i_dut (
        .aclk(aclk), .aresetn(aresetn),
        .s_valid(s_valid), .s_ready(s_ready), .s_data(s_data),
        .m_valid(m_valid), .m_ready(m_ready), .m_data(m_data)
    );

    always begin
        #2 aclk = 1'b1;
        #2 aclk = 1'b0;
    end

    function automatic longint fx_byte(longint v);
        longint b;
        b = (v * 255 + FX_ONE / 2) >>> FRAC_BITS;
        return (b > 255) ? 255 : b;
    endfunction

    function automatic longint hsl_channel(longint lo, longint hi, longint t6);
        if (t6 < 0) t6 += 6 * FX_ONE;
        if (t6 > 6 * FX_ONE) t6 -= 6 * FX_ONE;
        if (t6 < FX_ONE) return lo + (((hi - lo) * t6) >>> FRAC_BITS);
        if (t6 < 3 * FX_ONE) return hi;
        if (t6 < 4 * FX_ONE) return lo + (((hi - lo) * (4 * FX_ONE - t6)) >>> FRAC_BITS);
        return lo;
    endfunction

    function automatic rgb_out_t relight(rgb_in_t req);
        longint r, g, b, mx, mn, sum, lin, lnew, sat, hue, d, num, den;
        longint prod, hi, lo, ro, go, bo;
        rgb_out_t res;
        r = req.in_red;
        g = req.in_green;
        b = req.in_blue;
        mx = (r > g) ? r : g;
        mn = (r < g) ? r : g;
        if (b > mx) mx = b;
        if (b < mn) mn = b;
        sum = mx + mn;
        lin = (sum << FRAC_BITS) / 510;
        lnew = (longint'(req.brightness) << FRAC_BITS) / 255;
        sat = 0;
        hue = 0;
        if (mx != mn) begin
            d = mx - mn;
            den = (sum > 255) ? 510 - sum : sum;
            sat = (d << FRAC_BITS) / den;
            if (r > g && r > b) num = (g - b) + ((g < b) ? 6 * d : 0);
            else if (g > b) num = (b - r) + 2 * d;
            else num = (r - g) + 4 * d;
            if (num < 0) num = 0;
            hue = (num << FRAC_BITS) / (6 * d);
        end
        if (sat == 0) begin
            ro = lnew;
            go = lnew;
            bo = lnew;
        end else begin
            prod = (lnew * sat) >>> FRAC_BITS;
            hi = (lnew < FX_ONE / 2) ? lnew + prod : lnew + sat - prod;
            lo = (2 * lnew >= hi) ? 2 * lnew - hi : 0;
            ro = hsl_channel(lo, hi, 6 * hue + 2 * FX_ONE);
            go = hsl_channel(lo, hi, 6 * hue);
            bo = hsl_channel(lo, hi, 6 * hue - 2 * FX_ONE);
        end
        res.out_red = 8'(fx_byte(ro));
        res.out_green = 8'(fx_byte(go));
        res.out_blue = 8'(fx_byte(bo));
        res.in_lightness = 8'(fx_byte(lin));
        return res;
    endfunction

    function automatic rgb_in_t random_color();
        rgb_in_t req;
        int pick;
        req = rgb_in_t'($urandom);
        pick = $urandom_range(0, 9);
        // grey, ties between channels, extremes
        if (pick == 0) begin
            req.in_green = req.in_red;
            req.in_blue = req.in_red;
        end else if (pick == 1) begin
            req.in_green = req.in_red;
        end else if (pick == 2) begin
            req.in_blue = req.in_green;
        end else if (pick == 3) begin
            req.in_blue = req.in_red;
        end else if (pick == 4) begin
            req.brightness = ($urandom_range(0, 1) != 0) ? 8'd255 : 8'd0;
        end
        return req;
    endfunction

    table_row_t directed[$];

    task automatic add_row(logic [7:0] r, logic [7:0] g, logic [7:0] b, logic [7:0] br,
                           logic known, rgb_out_t res);
        table_row_t row;
        row.req = '{r, g, b, br};
        row.known = known;
        row.res = res;
        directed.push_back(row);
    endtask

    task automatic offer(rgb_in_t req);
        bit idle;
        idle = !steady && ($urandom_range(0, 99) < 35);
        while (idle) begin
            s_valid <= 1'b0;
            @(posedge aclk);
            idle = $urandom_range(0, 99) < 35;
        end
        s_valid <= 1'b1;
        s_data <= req;
        @(posedge aclk);
        while (!s_ready) @(posedge aclk);
    endtask

    initial begin
        table_row_t row;
        rgb_out_t res;
        rgb_in_t req;
        add_row(8'd0, 8'd0, 8'd0, 8'd0, 1'b1, '{8'd0, 8'd0, 8'd0, 8'd0});
        add_row(8'd255, 8'd255, 8'd255, 8'd255, 1'b1, '{8'd255, 8'd255, 8'd255, 8'd255});
        add_row(8'd0, 8'd0, 8'd0, 8'd255, 1'b1, '{8'd255, 8'd255, 8'd255, 8'd0});
        add_row(8'd255, 8'd255, 8'd255, 8'd0, 1'b1, '{8'd0, 8'd0, 8'd0, 8'd255});
        add_row(8'd255, 8'd0, 8'd0, 8'd0, 1'b1, '{8'd0, 8'd0, 8'd0, 8'd128});
        add_row(8'd255, 8'd0, 8'd0, 8'd255, 1'b1, '{8'd255, 8'd255, 8'd255, 8'd128});
        add_row(8'd100, 8'd100, 8'd100, 8'd77, 0, '0);
        add_row(8'd255, 8'd0, 8'd0, 8'd128, 0, '0);
        add_row(8'd0, 8'd255, 8'd0, 8'd128, 0, '0);
        add_row(8'd0, 8'd0, 8'd255, 8'd128, 0, '0);
        add_row(8'd255, 8'd255, 8'd0, 8'd128, 0, '0);
        add_row(8'd0, 8'd255, 8'd255, 8'd128, 0, '0);
        add_row(8'd255, 8'd0, 8'd255, 8'd128, 0, '0);
        add_row(8'd200, 8'd10, 8'd90, 8'd60, 0, '0);
        add_row(8'd200, 8'd200, 8'd3, 8'd170, 0, '0);
        add_row(8'd1, 8'd254, 8'd254, 8'd1, 0, '0);
        add_row(8'd10, 8'd10, 8'd240, 8'd254, 0, '0);
        add_row(8'd128, 8'd127, 8'd128, 8'd127, 0, '0);
        add_row(8'd170, 8'd85, 8'd0, 8'd200, 0, '0);

        repeat (2) @(posedge aclk);
        aresetn <= 1'b1;
        foreach (directed[i]) begin
            row = directed[i];
            res = row.known ? row.res : relight(row.req);
            expected_colors.push_back(res);
            offer(row.req);
        end
        for (int i = 0; i < RANDOM_COUNT; i++) begin
            steady = (i >= 300 && i < 450);
            if (i == 600) hold_off = 1'b1;
            req = random_color();
            expected_colors.push_back(relight(req));
            offer(req);
        end
        s_valid <= 1'b0;
        sending_done = 1'b1;
    end

    initial begin
        int held;
        held = 0;
        @(posedge aclk);
        forever begin
            if (hold_off && held < 300) begin
                m_ready <= 1'b0;
                held++;
            end else if (steady) begin
                m_ready <= 1'b1;
            end else begin
                m_ready <= ($urandom_range(0, 99) >= 35);
            end
            @(posedge aclk);
        end
    end

    always @(posedge aclk) begin
        rgb_out_t want;
        if (aresetn && m_valid && m_ready) begin
            if (expected_colors.size() == 0) begin
                $error("unexpected result %h", m_data);
                failures++;
            end else begin
                want = expected_colors.pop_front();
                if (m_data.out_red !== want.out_red) begin
                    $error("out_red expected %0d got %0d", want.out_red, m_data.out_red);
                    failures++;
                end
                if (m_data.out_green !== want.out_green) begin
                    $error("out_green expected %0d got %0d", want.out_green, m_data.out_green);
                    failures++;
                end
                if (m_data.out_blue !== want.out_blue) begin
                    $error("out_blue expected %0d got %0d", want.out_blue, m_data.out_blue);
                    failures++;
                end
                if (m_data.in_lightness !== want.in_lightness) begin
                    $error("in_lightness expected %0d got %0d",
                           want.in_lightness, m_data.in_lightness);
                    failures++;
                end
            end
        end
    end

    always @(posedge aclk) begin
        if ((s_valid && s_ready) || (m_valid && m_ready)) quiet_cycles <= 0;
        else quiet_cycles <= quiet_cycles + 1;
        if (quiet_cycles > STALL_LIMIT) begin
            $display("rgb_lightness_adjust_tb NOT OK");
            $finish;
        end
    end

    initial begin
        wait (sending_done && expected_colors.size() == 0);
        repeat (DRAIN_CYCLES) @(posedge aclk);
        if (failures == 0) begin
            $display("rgb_lightness_adjust_tb OK");
        end else begin
            $display("rgb_lightness_adjust_tb NOT OK");
        end
        $finish;
    end
endmodule
